// File: sv/pba_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the page bitmap allocator.
package pba_pkg;

  localparam int CMD_W   = 3;
  localparam int OWNER_W = 16;
  localparam int COUNT_W = 14;
  localparam int INDEX_W = 13;
  localparam int START_W = 13;

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC      = 3'd0,
    CMD_FREE       = 3'd1,
    CMD_FREE_OWNER = 3'd2,
    CMD_QUERY      = 3'd3,
    CMD_SET_USED   = 3'd4,
    CMD_SET_OWNER  = 3'd5
  } cmd_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_MARK,
    ST_FREE,
    ST_OWN_SCAN,
    ST_READ,
    ST_WB,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [CMD_W-1:0]   command;
    logic [OWNER_W-1:0] owner_id;
    logic [COUNT_W-1:0] page_count;
    logic [INDEX_W-1:0] page_index;
    logic               used_flag;
  } cmd_word_t;

  typedef struct packed {
    logic               ok;
    logic [START_W-1:0] start_page;
    logic               page_used;
    logic [OWNER_W-1:0] page_owner;
  } res_word_t;

  localparam res_word_t RES_DEFAULT = '{ok: 1'b1, start_page: '0, page_used: 1'b0,
                                        page_owner: '0};

endpackage

// File: sv/pba_if.sv
`timescale 1ns / 1ps
// Command and result channel interfaces of the page bitmap allocator.
interface pba_cmd_if;
  logic                         valid;
  logic                         ready;
  logic [pba_pkg::CMD_W-1:0]    command;
  logic [pba_pkg::OWNER_W-1:0]  owner_id;
  logic [pba_pkg::COUNT_W-1:0]  page_count;
  logic [pba_pkg::INDEX_W-1:0]  page_index;
  logic                         used_flag;

  modport source (output valid, command, owner_id, page_count, page_index, used_flag,
                  input ready);
  modport sink (input valid, command, owner_id, page_count, page_index, used_flag,
                output ready);
endinterface

interface pba_res_if;
  logic                         valid;
  logic                         ready;
  logic                         ok;
  logic [pba_pkg::START_W-1:0]  start_page;
  logic                         page_used;
  logic [pba_pkg::OWNER_W-1:0]  page_owner;

  modport source (output valid, ok, start_page, page_used, page_owner, input ready);
  modport sink (input valid, ok, start_page, page_used, page_owner, output ready);
endinterface

// File: sv/page_bitmap_allocator_unit.sv
`timescale 1ns / 1ps
// Page bitmap allocator: first-fit contiguous page allocation over a page map.
// Channels: in_cmd takes one command word (alloc, free, free by owner, query,
// set used, set owner); out_res gives exactly one result word per command.
// Both use valid/ready; a word moves on a clock edge with both high.
// The used bit and owner of every page sit in one synchronous memory.
// Reset (rst_n low, synchronous) starts a clearing pass over all NUM_PAGES pages
// that marks pages below RESERVED_PAGES used and zeroes every owner; in_cmd
// is not ready until it ends.
// One command is worked on at a time; its steps, set by the single memory
// read port:
//   alloc: scan pages from RESERVED_PAGES up for a free run, then mark
//          page_count pages
//   free: clear up to page_count pages, stopping at the map's end;  free by owner: scan all pages
//   query and set: read one page, set writes it back;  unused codes: no access
// The result waits in an output register; a stalled receiver does not stop
// the next command being accepted, but that command's result holds until the
// register is taken.
module page_bitmap_allocator_unit #(
  parameter int unsigned NUM_PAGES      = 8192,
  parameter int unsigned RESERVED_PAGES = 4096,
  parameter int unsigned OWNER_BITS     = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  pba_cmd_if.sink    in_cmd,
  pba_res_if.source  out_res
);

  localparam int unsigned PAGE_W = $clog2(NUM_PAGES);
  localparam int unsigned ENT_W  = OWNER_BITS + 1;

  pba_pkg::cmd_word_t in_word;
  pba_pkg::res_word_t seq_res;
  pba_pkg::res_word_t out_res_r;
  logic               out_valid_r;
  logic               seq_idle;
  logic               seq_done;
  logic               res_take;
  logic               start;

  logic              mem_rd_en;
  logic [PAGE_W-1:0] mem_rd_addr;
  logic [ENT_W-1:0]  mem_rd_data;
  logic              mem_wr_en;
  logic [PAGE_W-1:0] mem_wr_addr;
  logic [ENT_W-1:0]  mem_wr_data;

  assign in_word = '{command: in_cmd.command, owner_id: in_cmd.owner_id,
                     page_count: in_cmd.page_count, page_index: in_cmd.page_index,
                     used_flag: in_cmd.used_flag};

  assign in_cmd.ready = seq_idle;
  assign start        = in_cmd.valid && seq_idle;
  assign res_take     = seq_done && (!out_valid_r || out_res.ready);

  pba_seq #(
    .NUM_PAGES      (NUM_PAGES),
    .RESERVED_PAGES (RESERVED_PAGES),
    .OWNER_BITS     (OWNER_BITS),
    .PAGE_W         (PAGE_W),
    .ENT_W          (ENT_W)
  ) u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .cmd         (in_word),
    .idle        (seq_idle),
    .done        (seq_done),
    .res         (seq_res),
    .res_take    (res_take),
    .mem_rd_en   (mem_rd_en),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data)
  );

  pba_page_mem #(
    .DEPTH  (NUM_PAGES),
    .WIDTH  (ENT_W),
    .ADDR_W (PAGE_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= 1'b1;
    end else if (out_res.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_res_r <= seq_res;
    end
  end

  assign out_res.valid      = out_valid_r;
  assign out_res.ok         = out_res_r.ok;
  assign out_res.start_page = out_res_r.start_page;
  assign out_res.page_used  = out_res_r.page_used;
  assign out_res.page_owner = out_res_r.page_owner;

endmodule

// File: sv/pba_page_mem.sv
`timescale 1ns / 1ps
// Page map memory: one write port, one read port, registered read data.
module pba_page_mem #(
  parameter int unsigned DEPTH  = 8192,
  parameter int unsigned WIDTH  = 17,
  parameter int unsigned ADDR_W = 13
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: sv/pba_seq.sv
`timescale 1ns / 1ps
// Command sequencer: clearing pass, scans and read-modify-write of the page map.
module pba_seq #(
  parameter int unsigned NUM_PAGES      = 8192,
  parameter int unsigned RESERVED_PAGES = 4096,
  parameter int unsigned OWNER_BITS     = 16,
  parameter int unsigned PAGE_W         = 13,
  parameter int unsigned ENT_W          = 17
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  pba_pkg::cmd_word_t  cmd,
  output logic                idle,
  output logic                done,
  output pba_pkg::res_word_t  res,
  input  logic                res_take,
  output logic                mem_rd_en,
  output logic [PAGE_W-1:0]   mem_rd_addr,
  input  logic [ENT_W-1:0]    mem_rd_data,
  output logic                mem_wr_en,
  output logic [PAGE_W-1:0]   mem_wr_addr,
  output logic [ENT_W-1:0]    mem_wr_data
);

  localparam int unsigned CNT_W = $clog2(NUM_PAGES + 1);
  localparam int unsigned AW    = ((CNT_W > 15) ? CNT_W : 15) + 1;
  localparam bit ALLOC_EMPTY    = (RESERVED_PAGES >= NUM_PAGES);

  pba_pkg::state_e    state_r, state_nxt;
  pba_pkg::cmd_word_t cmd_r, cmd_nxt;
  pba_pkg::res_word_t res_r, res_nxt;
  logic [CNT_W-1:0]   ptr_r, ptr_nxt;
  logic [CNT_W-1:0]   run_r, run_nxt;
  logic [PAGE_W-1:0]  first_r, first_nxt;
  logic [pba_pkg::COUNT_W-1:0] k_r, k_nxt;
  logic               rd_vld_r, rd_vld_nxt;
  logic [PAGE_W-1:0]  rd_addr_r, rd_addr_nxt;

  logic                  scan_issue;
  logic                  ent_used;
  logic [OWNER_BITS-1:0] ent_owner;
  logic [OWNER_BITS-1:0] own_in;
  logic [AW-1:0]         run_inc;
  logic                  run_hit;
  logic [PAGE_W-1:0]     first_sel;
  logic [AW-1:0]         mark_addr;
  logic [AW-1:0]         free_addr;
  logic                  clr_used;

  assign scan_issue = (ptr_r != CNT_W'(NUM_PAGES));
  assign ent_used   = mem_rd_data[OWNER_BITS];
  assign ent_owner  = mem_rd_data[OWNER_BITS-1:0];
  assign own_in     = OWNER_BITS'(cmd_r.owner_id);
  assign run_inc    = AW'(run_r) + AW'(1);
  assign run_hit    = rd_vld_r && !ent_used && (run_inc >= AW'(cmd_r.page_count));
  assign first_sel  = (run_r == '0) ? rd_addr_r : first_r;
  assign mark_addr  = AW'(first_r) + AW'(k_r);
  assign free_addr  = AW'(cmd_r.page_index) + AW'(k_r);
  assign clr_used   = (32'(ptr_r) < RESERVED_PAGES);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= pba_pkg::ST_CLEAR;
      ptr_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ptr_r    <= ptr_nxt;
      rd_vld_r <= rd_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r     <= cmd_nxt;
    res_r     <= res_nxt;
    run_r     <= run_nxt;
    first_r   <= first_nxt;
    k_r       <= k_nxt;
    rd_addr_r <= rd_addr_nxt;
  end

  always_comb begin
    state_nxt   = state_r;
    cmd_nxt     = cmd_r;
    res_nxt     = res_r;
    ptr_nxt     = ptr_r;
    run_nxt     = run_r;
    first_nxt   = first_r;
    k_nxt       = k_r;
    rd_vld_nxt  = 1'b0;
    rd_addr_nxt = rd_addr_r;
    mem_rd_en   = 1'b0;
    mem_rd_addr = ptr_r[PAGE_W-1:0];
    mem_wr_en   = 1'b0;
    mem_wr_addr = ptr_r[PAGE_W-1:0];
    mem_wr_data = '0;
    case (state_r)
      pba_pkg::ST_CLEAR: begin
        mem_wr_en   = 1'b1;
        mem_wr_data = {clr_used, {OWNER_BITS{1'b0}}};
        ptr_nxt     = ptr_r + 1'b1;
        if (ptr_r == CNT_W'(NUM_PAGES - 1)) begin
          state_nxt = pba_pkg::ST_IDLE;
        end
      end
      pba_pkg::ST_IDLE: begin
        if (start) begin
          cmd_nxt = cmd;
          res_nxt = pba_pkg::RES_DEFAULT;
          k_nxt   = '0;
          run_nxt = '0;
          ptr_nxt = '0;
          case (cmd.command)
            pba_pkg::CMD_ALLOC: begin
              if (ALLOC_EMPTY) begin
                res_nxt.ok = 1'b0;
                state_nxt  = pba_pkg::ST_DONE;
              end else begin
                ptr_nxt   = CNT_W'(RESERVED_PAGES);
                state_nxt = pba_pkg::ST_SCAN;
              end
            end
            pba_pkg::CMD_FREE:       state_nxt = pba_pkg::ST_FREE;
            pba_pkg::CMD_FREE_OWNER: state_nxt = pba_pkg::ST_OWN_SCAN;
            pba_pkg::CMD_QUERY, pba_pkg::CMD_SET_USED, pba_pkg::CMD_SET_OWNER:
              state_nxt = pba_pkg::ST_READ;
            default:                 state_nxt = pba_pkg::ST_DONE;
          endcase
        end
      end
      pba_pkg::ST_SCAN: begin
        mem_rd_en   = scan_issue;
        rd_vld_nxt  = scan_issue;
        rd_addr_nxt = ptr_r[PAGE_W-1:0];
        if (scan_issue) begin
          ptr_nxt = ptr_r + 1'b1;
        end
        if (rd_vld_r) begin
          if (ent_used) begin
            run_nxt = '0;
          end else begin
            run_nxt   = run_r + 1'b1;
            first_nxt = first_sel;
          end
        end
        if (run_hit) begin
          mem_rd_en  = 1'b0;
          rd_vld_nxt = 1'b0;
          k_nxt      = '0;
          if (cmd_r.page_count == '0) begin
            res_nxt.start_page = pba_pkg::START_W'(first_sel);
            state_nxt          = pba_pkg::ST_DONE;
          end else begin
            state_nxt = pba_pkg::ST_MARK;
          end
        end else if (!scan_issue) begin
          res_nxt.ok = 1'b0;
          state_nxt  = pba_pkg::ST_DONE;
        end
      end
      pba_pkg::ST_MARK: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = mark_addr[PAGE_W-1:0];
        mem_wr_data = {1'b1, own_in};
        k_nxt       = k_r + 1'b1;
        if (k_r == cmd_r.page_count - 1'b1) begin
          res_nxt.start_page = pba_pkg::START_W'(first_r);
          state_nxt          = pba_pkg::ST_DONE;
        end
      end
      pba_pkg::ST_FREE: begin
        mem_wr_addr = free_addr[PAGE_W-1:0];
        if (k_r == cmd_r.page_count || free_addr >= AW'(NUM_PAGES)) begin
          state_nxt = pba_pkg::ST_DONE;
        end else begin
          mem_wr_en = 1'b1;
          k_nxt     = k_r + 1'b1;
        end
      end
      pba_pkg::ST_OWN_SCAN: begin
        mem_rd_en   = scan_issue;
        rd_vld_nxt  = scan_issue;
        rd_addr_nxt = ptr_r[PAGE_W-1:0];
        mem_wr_addr = rd_addr_r;
        if (scan_issue) begin
          ptr_nxt = ptr_r + 1'b1;
        end
        if (rd_vld_r && ent_owner == own_in) begin
          mem_wr_en = 1'b1;
        end
        if (!scan_issue) begin
          state_nxt = pba_pkg::ST_DONE;
        end
      end
      pba_pkg::ST_READ: begin
        mem_rd_addr = PAGE_W'(cmd_r.page_index);
        if (AW'(cmd_r.page_index) >= AW'(NUM_PAGES)) begin
          state_nxt = pba_pkg::ST_DONE;
        end else begin
          mem_rd_en = 1'b1;
          state_nxt = pba_pkg::ST_WB;
        end
      end
      pba_pkg::ST_WB: begin
        mem_wr_addr = PAGE_W'(cmd_r.page_index);
        case (cmd_r.command)
          pba_pkg::CMD_QUERY: begin
            res_nxt.page_used  = ent_used;
            res_nxt.page_owner = pba_pkg::OWNER_W'(ent_owner);
          end
          pba_pkg::CMD_SET_USED: begin
            mem_wr_en   = 1'b1;
            mem_wr_data = {cmd_r.used_flag, ent_owner};
          end
          pba_pkg::CMD_SET_OWNER: begin
            mem_wr_en   = 1'b1;
            mem_wr_data = {ent_used, own_in};
          end
          default: ;
        endcase
        state_nxt = pba_pkg::ST_DONE;
      end
      pba_pkg::ST_DONE: begin
        if (res_take) begin
          state_nxt = pba_pkg::ST_IDLE;
        end
      end
      default: state_nxt = pba_pkg::ST_IDLE;
    endcase
  end

  assign idle = (state_r == pba_pkg::ST_IDLE);
  assign done = (state_r == pba_pkg::ST_DONE);
  assign res  = res_r;

endmodule

// File: sv/pba_checker.sv
`timescale 1ns / 1ps
// Port-level checks of the page bitmap allocator and their bind.
module pba_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic                        out_ok,
  input logic [pba_pkg::START_W-1:0] out_start_page,
  input logic                        out_page_used,
  input logic [pba_pkg::OWNER_W-1:0] out_page_owner
);

  // no command taken in the cycle after reset: clearing pass runs
  a_clear_after_reset: assert property (@(posedge clk) !rst_n |=> !in_ready)
    else $error("in_cmd ready straight after reset");

  // one command at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("in_cmd ready again right after a word was taken");

  a_fail_start_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ok) |-> (out_start_page == '0 && !out_page_used
                                && out_page_owner == '0))
    else $error("failed alloc result carries non-zero fields");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_ok)
                                   && $stable(out_start_page)
                                   && $stable(out_page_owner)))
    else $error("stalled result word changed");

endmodule

bind page_bitmap_allocator_unit pba_checker u_pba_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_cmd.valid),
  .in_ready       (in_cmd.ready),
  .out_valid      (out_res.valid),
  .out_ready      (out_res.ready),
  .out_ok         (out_res.ok),
  .out_start_page (out_res.start_page),
  .out_page_used  (out_res.page_used),
  .out_page_owner (out_res.page_owner)
);

// File: test/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench of the page bitmap allocator: directed and random commands.
module tb;

  localparam int NUM_PAGES      = 8192;
  localparam int RESERVED_PAGES = 4096;
  localparam int OWNER_BITS     = 16;
  localparam logic [pba_pkg::CMD_W-1:0] CMD_SPARE_6 = 3'd6;
  localparam logic [pba_pkg::CMD_W-1:0] CMD_SPARE_7 = 3'd7;

  logic clk;
  logic rst_n;

  pba_cmd_if cmd_bus ();
  pba_res_if res_bus ();

  page_bitmap_allocator_unit #(
    .NUM_PAGES(NUM_PAGES),
    .RESERVED_PAGES(RESERVED_PAGES),
    .OWNER_BITS(OWNER_BITS)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_cmd(cmd_bus),
    .out_res(res_bus)
  );

  bit                          used_map [NUM_PAGES];
  logic [pba_pkg::OWNER_W-1:0] owner_map [NUM_PAGES];

  pba_pkg::cmd_word_t cmd_pending_q [$];
  pba_pkg::res_word_t res_expected_q [$];
  int        cmds_total;
  int        cmds_taken;
  int        error_cnt;
  bit        cmd_taken;
  int        burst_left;
  int        gap_left;
  int        stall_left;
  logic [15:0] rx_cycle;

  always #5 clk = ~clk;

  function automatic pba_pkg::res_word_t predict_result(pba_pkg::cmd_word_t w);
    pba_pkg::res_word_t r;
    int run;
    int first;
    bit found;
    r = pba_pkg::RES_DEFAULT;
    run = 0;
    first = 0;
    found = 1'b0;
    case (w.command)
      pba_pkg::CMD_ALLOC: begin
        for (int p = RESERVED_PAGES; p < NUM_PAGES && !found; p++) begin
          if (!used_map[p]) begin
            if (run == 0) first = p;
            run++;
            if (run >= int'(w.page_count)) found = 1'b1;
          end else begin
            run = 0;
          end
        end
        if (found) begin
          for (int i = 0; i < int'(w.page_count); i++) begin
            used_map[first + i]  = 1'b1;
            owner_map[first + i] = w.owner_id;
          end
          r.start_page = pba_pkg::START_W'(first);
        end else begin
          r.ok = 1'b0;
        end
      end
      pba_pkg::CMD_FREE: begin
        for (int i = 0; i < int'(w.page_count); i++) begin
          if (int'(w.page_index) + i < NUM_PAGES) begin
            used_map[int'(w.page_index) + i]  = 1'b0;
            owner_map[int'(w.page_index) + i] = '0;
          end
        end
      end
      pba_pkg::CMD_FREE_OWNER: begin
        for (int p = 0; p < NUM_PAGES; p++) begin
          if (owner_map[p] == w.owner_id) begin
            used_map[p]  = 1'b0;
            owner_map[p] = '0;
          end
        end
      end
      pba_pkg::CMD_QUERY: begin
        r.page_used  = used_map[w.page_index];
        r.page_owner = owner_map[w.page_index];
      end
      pba_pkg::CMD_SET_USED:  used_map[w.page_index] = w.used_flag;
      pba_pkg::CMD_SET_OWNER: owner_map[w.page_index] = w.owner_id;
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("ERROR at %0t: %s", $realtime, msg);
    error_cnt++;
  endtask

  task automatic add_cmd(input logic [pba_pkg::CMD_W-1:0] c,
                         input logic [pba_pkg::OWNER_W-1:0] own,
                         input int cnt, input int idx, input bit flag);
    pba_pkg::cmd_word_t w;
    w.command    = c;
    w.owner_id   = own;
    w.page_count = pba_pkg::COUNT_W'(cnt);
    w.page_index = pba_pkg::INDEX_W'(idx);
    w.used_flag  = flag;
    cmd_pending_q.push_back(w);
  endtask

  // monitor: predict on command acceptance, check on result acceptance
  always @(posedge clk) begin
    pba_pkg::res_word_t got;
    pba_pkg::res_word_t exp;
    pba_pkg::cmd_word_t w;
    cmd_taken = rst_n && cmd_bus.valid && cmd_bus.ready;
    if (cmd_taken) begin
      w.command    = cmd_bus.command;
      w.owner_id   = cmd_bus.owner_id;
      w.page_count = cmd_bus.page_count;
      w.page_index = cmd_bus.page_index;
      w.used_flag  = cmd_bus.used_flag;
      res_expected_q.push_back(predict_result(w));
      cmds_taken++;
    end
    if (rst_n && res_bus.valid && res_bus.ready) begin
      got.ok         = res_bus.ok;
      got.start_page = res_bus.start_page;
      got.page_used  = res_bus.page_used;
      got.page_owner = res_bus.page_owner;
      if (res_expected_q.size() == 0) begin
        report_mismatch($sformatf("result word with nothing expected: %p", got));
      end else begin
        exp = res_expected_q.pop_front();
        if (got.ok !== exp.ok)
          report_mismatch($sformatf("ok %b, expected %b", got.ok, exp.ok));
        if (got.start_page !== exp.start_page)
          report_mismatch($sformatf("start_page %0d, expected %0d",
                                    got.start_page, exp.start_page));
        if (got.page_used !== exp.page_used)
          report_mismatch($sformatf("page_used %b, expected %b",
                                    got.page_used, exp.page_used));
        if (got.page_owner !== exp.page_owner)
          report_mismatch($sformatf("page_owner %h, expected %h",
                                    got.page_owner, exp.page_owner));
      end
    end
  end

  // driver: bursts of words with random gaps
  always @(negedge clk) begin
    pba_pkg::cmd_word_t w;
    if (!rst_n) begin
      cmd_bus.valid <= 1'b0;
    end else if (!cmd_bus.valid || cmd_taken) begin
      if (cmd_bus.valid) begin
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 10);
          case ($urandom_range(0, 5))
            0, 1:    gap_left = 0;
            2:       gap_left = $urandom_range(10, 40);
            default: gap_left = $urandom_range(1, 8);
          endcase
        end
      end
      if (gap_left > 0) begin
        gap_left--;
        cmd_bus.valid <= 1'b0;
      end else if (cmd_pending_q.size() != 0) begin
        w = cmd_pending_q.pop_front();
        cmd_bus.valid      <= 1'b1;
        cmd_bus.command    <= w.command;
        cmd_bus.owner_id   <= w.owner_id;
        cmd_bus.page_count <= w.page_count;
        cmd_bus.page_index <= w.page_index;
        cmd_bus.used_flag  <= w.used_flag;
      end else begin
        cmd_bus.valid <= 1'b0;
      end
    end
  end

  // receiver: random stalls, started only while bit 9 of rx_cycle is set
  always @(negedge clk) begin
    rx_cycle <= rx_cycle + 16'd1;
    if (stall_left > 0) begin
      stall_left--;
      res_bus.ready <= 1'b0;
    end else if (rx_cycle[9] && $urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(0, 24);
      res_bus.ready <= 1'b0;
    end else begin
      res_bus.ready <= 1'b1;
    end
  end

  initial begin
    #60_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    int sel;
    int cnt;
    int near;
    logic [pba_pkg::OWNER_W-1:0] own;
    clk               = 1'b0;
    rst_n             = 1'b0;
    cmd_bus.valid      = 1'b0;
    cmd_bus.command    = '0;
    cmd_bus.owner_id   = '0;
    cmd_bus.page_count = '0;
    cmd_bus.page_index = '0;
    cmd_bus.used_flag  = 1'b0;
    res_bus.ready      = 1'b0;
    rx_cycle          = '0;
    cmds_taken        = 0;
    error_cnt         = 0;
    cmd_taken         = 1'b0;
    burst_left        = 3;
    gap_left          = 0;
    stall_left        = 0;
    for (int p = 0; p < NUM_PAGES; p++) begin
      used_map[p]  = (p < RESERVED_PAGES);
      owner_map[p] = '0;
    end

    // directed
    add_cmd(pba_pkg::CMD_QUERY, 16'h0000, 0, 0, 1'b0);
    add_cmd(pba_pkg::CMD_QUERY, 16'hFFFF, 16383, NUM_PAGES - 1, 1'b1);
    add_cmd(pba_pkg::CMD_ALLOC, 16'hFFFF, 0, 0, 1'b0);     // zero pages: marks nothing
    add_cmd(pba_pkg::CMD_ALLOC, 16'hFFFF, 1, 0, 1'b0);
    add_cmd(pba_pkg::CMD_ALLOC, 16'h0001, 3, NUM_PAGES - 1, 1'b1);
    add_cmd(pba_pkg::CMD_QUERY, 16'h0000, 0, RESERVED_PAGES + 1, 1'b0);
    add_cmd(pba_pkg::CMD_ALLOC, 16'h1234, NUM_PAGES, 0, 1'b0);      // fails
    add_cmd(pba_pkg::CMD_ALLOC, 16'h8000, RESERVED_PAGES, 0, 1'b0); // fails, nothing marked
    add_cmd(pba_pkg::CMD_QUERY, 16'h0000, 0, RESERVED_PAGES + 10, 1'b0);
    add_cmd(pba_pkg::CMD_SET_OWNER, 16'hAAAA, 0, 4200, 1'b0);
    add_cmd(pba_pkg::CMD_SET_USED, 16'h0000, 0, 4200, 1'b1);
    add_cmd(pba_pkg::CMD_QUERY, 16'h0000, 0, 4200, 1'b0);
    add_cmd(pba_pkg::CMD_SET_USED, 16'h5555, 0, 4200, 1'b0);
    add_cmd(pba_pkg::CMD_FREE_OWNER, 16'hAAAA, 0, 0, 1'b0);
    add_cmd(pba_pkg::CMD_FREE, 16'h0000, 2, RESERVED_PAGES, 1'b0);
    add_cmd(pba_pkg::CMD_FREE_OWNER, 16'h0000, 0, 0, 1'b0);  // owner zero, reserved included
    add_cmd(pba_pkg::CMD_QUERY, 16'h0000, 0, 0, 1'b0);
    add_cmd(pba_pkg::CMD_FREE, 16'h0000, 100, NUM_PAGES - 2, 1'b0); // runs past the end
    add_cmd(pba_pkg::CMD_ALLOC, 16'h5555, 4092, 0, 1'b0);
    add_cmd(pba_pkg::CMD_ALLOC, 16'h0002, 1, 0, 1'b0);
    add_cmd(pba_pkg::CMD_FREE, 16'h0000, NUM_PAGES, 0, 1'b0);
    add_cmd(CMD_SPARE_6, 16'hFFFF, 16383, NUM_PAGES - 1, 1'b1);
    add_cmd(CMD_SPARE_7, 16'h0F0F, 77, 4500, 1'b0);
    add_cmd(pba_pkg::CMD_SET_OWNER, 16'hFFFF, 0, NUM_PAGES - 1, 1'b1);
    add_cmd(pba_pkg::CMD_QUERY, 16'h0000, 0, NUM_PAGES - 1, 1'b0);

    // random, centred on the allocation area above the reserved pages
    for (int k = 0; k < 75; k++) begin
      sel  = $urandom_range(0, 99);
      near = ($urandom_range(0, 4) != 0) ? RESERVED_PAGES + $urandom_range(0, 511)
                                         : $urandom_range(0, NUM_PAGES - 1);
      own  = ($urandom_range(0, 3) == 0) ? pba_pkg::OWNER_W'($urandom)
                                         : pba_pkg::OWNER_W'($urandom_range(1, 6));
      if (sel < 30) begin
        cnt = ($urandom_range(0, 19) == 0) ? $urandom_range(0, NUM_PAGES)
                                           : $urandom_range(0, 24);
        add_cmd(pba_pkg::CMD_ALLOC, own, cnt, $urandom_range(0, NUM_PAGES - 1),
                $urandom_range(0, 1));
      end else if (sel < 45) begin
        cnt = ($urandom_range(0, 9) == 0) ? $urandom_range(0, NUM_PAGES)
                                          : $urandom_range(0, 32);
        add_cmd(pba_pkg::CMD_FREE, own, cnt, near, $urandom_range(0, 1));
      end else if (sel < 52) begin
        add_cmd(pba_pkg::CMD_FREE_OWNER, own, $urandom_range(0, NUM_PAGES), near,
                $urandom_range(0, 1));
      end else if (sel < 80) begin
        add_cmd(pba_pkg::CMD_QUERY, own, $urandom_range(0, NUM_PAGES), near,
                $urandom_range(0, 1));
      end else if (sel < 89) begin
        add_cmd(pba_pkg::CMD_SET_USED, own, $urandom_range(0, NUM_PAGES), near,
                $urandom_range(0, 1));
      end else if (sel < 98) begin
        add_cmd(pba_pkg::CMD_SET_OWNER, own, $urandom_range(0, NUM_PAGES), near,
                $urandom_range(0, 1));
      end else begin
        add_cmd(sel[0] ? CMD_SPARE_7 : CMD_SPARE_6, own, $urandom_range(0, NUM_PAGES), near,
                $urandom_range(0, 1));
      end
    end
    cmds_total = cmd_pending_q.size();

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (cmds_taken != cmds_total || res_expected_q.size() != 0) @(posedge clk);
    repeat (NUM_PAGES + 16) @(posedge clk);

    if (error_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
